/* rtl/binary_trie_order_statistics_top_defines.svh */
// Assertion macros used by the port checker of the trie block.
`ifndef BINARY_TRIE_ORDER_STATISTICS_TOP_DEFINES_SVH
`define BINARY_TRIE_ORDER_STATISTICS_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BTO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trie block assertion failed");

// Next-cycle implication, checked outside reset.
`define BTO_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trie block assertion failed");

`endif

/* rtl/bto_pkg.sv */
// Package with the shared types, codes and defaults of the trie block.
`default_nettype none

package bto_pkg;

    localparam int KEY_BITS_DEF   = 10;
    localparam int COUNT_BITS_DEF = 16;
    localparam int RANK_BITS      = 16;
    localparam int REQ_BITS       = 3;
    localparam int STATUS_BITS    = 2;

    localparam logic [REQ_BITS-1:0] REQ_INS = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_DEL = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_MEM = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_KTH = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_CNT = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_SUM = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_RANK   = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_FIRST, S_UPD, S_KTH, S_CS, S_CSLEAF, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_START, OP_FIRST, OP_UPD, OP_KTH, OP_CS, OP_CSLEAF, OP_LOAD
    } t_op;

    typedef enum logic [2:0] {
        PH_FIRST, PH_UPD, PH_KTH, PH_CS, PH_CSLEAF, PH_DONE
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   clr_last;
        logic   out_full;
    } t_dp_sts;

    function automatic t_state ph2state(input t_phase ph);
        t_state st;
        unique case (ph)
            PH_FIRST:  st = S_FIRST;
            PH_UPD:    st = S_UPD;
            PH_KTH:    st = S_KTH;
            PH_CS:     st = S_CS;
            PH_CSLEAF: st = S_CSLEAF;
            default:   st = S_OUT;
        endcase
        return st;
    endfunction

endpackage

`default_nettype wire

/* rtl/bto_dp.sv */
// Datapath of the trie block: node memory, walk registers and result register.
`default_nettype none

module bto_dp import bto_pkg::*; #(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int IDW        = 40,
    parameter int ODW        = 56
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_op                    i_op,
    input  wire logic [REQ_BITS-1:0]    i_req,
    input  wire logic [IDW-1:0]         i_data,
    output t_dp_sts                     o_sts,
    input  wire logic                   i_tready,
    output logic                        o_tvalid,
    output logic [ODW-1:0]              o_tdata,
    output logic [STATUS_BITS-1:0]      o_tuser
);

    localparam int NA = KEY_BITS + 1;
    localparam int SW = KEY_BITS + COUNT_BITS;
    localparam int LW = $clog2(KEY_BITS);
    localparam int CW = (COUNT_BITS > RANK_BITS) ? COUNT_BITS : RANK_BITS;
    localparam int MW = COUNT_BITS + SW;

    logic [MW-1:0] r_mem [0:(2**NA)-1];
    logic [MW-1:0] r_rd_data;

    logic [REQ_BITS-1:0]    r_req, n_req;
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [RANK_BITS-1:0]   r_k, n_k;
    logic [KEY_BITS-1:0]    r_bnd, n_bnd;
    logic [NA-1:0]          r_node, n_node;
    logic [LW-1:0]          r_lvl, n_lvl;
    logic [STATUS_BITS-1:0] r_status, n_status;
    logic                   r_found, n_found;
    logic [KEY_BITS-1:0]    r_ans, n_ans;
    logic [COUNT_BITS-1:0]  r_cacc, n_cacc;
    logic [SW-1:0]          r_sacc, n_sacc;
    logic [NA-1:0]          r_clr, n_clr;
    logic                   r_out_valid;
    logic [ODW-1:0]         r_out_data;
    logic [STATUS_BITS-1:0] r_out_user;

    logic [KEY_BITS-1:0]   in_key;
    logic [RANK_BITS-1:0]  in_rank;
    logic [KEY_BITS:0]     in_bound;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [SW-1:0]         rd_sum;
    logic                  rd_en, wr_en, upd_go, kb, kb_nx, bb;
    logic [NA-1:0]         rd_addr, wr_addr, node_new;
    logic [MW-1:0]         wr_data;
    t_phase                phase;
    logic [LW-1:0]         lvl_dec;

    assign in_key   = i_data[KEY_BITS-1:0];
    assign in_rank  = i_data[KEY_BITS+RANK_BITS-1:KEY_BITS];
    assign in_bound = i_data[2*KEY_BITS+RANK_BITS:KEY_BITS+RANK_BITS];
    assign rd_cnt   = r_rd_data[MW-1:SW];
    assign rd_sum   = r_rd_data[SW-1:0];
    assign lvl_dec  = r_lvl - LW'(1);
    assign kb       = r_key[r_lvl];
    assign kb_nx    = r_key[lvl_dec];
    assign bb       = r_bnd[r_lvl];

    always_comb begin
        n_req = r_req; n_key = r_key; n_k = r_k; n_bnd = r_bnd; n_node = r_node;
        n_lvl = r_lvl; n_status = r_status; n_found = r_found; n_ans = r_ans;
        n_cacc = r_cacc; n_sacc = r_sacc; n_clr = r_clr;
        rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
        upd_go = 1'b0; node_new = '0; phase = PH_DONE;
        unique case (i_op)
            OP_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = r_clr;
                n_clr = r_clr + NA'(1);
            end
            OP_START: begin
                n_req = i_req; n_key = in_key; n_k = in_rank; n_bnd = in_bound[KEY_BITS-1:0];
                n_status = ST_OK; n_found = 1'b0; n_ans = '0; n_cacc = '0; n_sacc = '0;
                n_lvl = LW'(KEY_BITS - 1);
                unique case (i_req)
                    REQ_INS, REQ_KTH: begin
                        rd_en = 1'b1; rd_addr = NA'(1); phase = PH_FIRST;
                    end
                    REQ_DEL, REQ_MEM: begin
                        rd_en = 1'b1; rd_addr = {1'b1, in_key}; n_node = {1'b1, in_key};
                        phase = PH_FIRST;
                    end
                    REQ_CNT, REQ_SUM: begin
                        if (!in_bound[KEY_BITS]) begin
                            rd_en = 1'b1; rd_addr = NA'(2); n_node = NA'(1); phase = PH_CS;
                        end
                    end
                    default: phase = PH_DONE;
                endcase
            end
            OP_FIRST: begin
                unique case (r_req)
                    REQ_INS: begin
                        if (rd_cnt == '1) begin
                            n_status = ST_FULL;
                        end else begin
                            rd_en = 1'b1; rd_addr = {1'b1, r_key}; n_node = {1'b1, r_key};
                            phase = PH_UPD;
                        end
                    end
                    REQ_DEL: begin
                        if (rd_cnt == '0) n_status = ST_ABSENT;
                        else upd_go = 1'b1;
                    end
                    REQ_MEM: n_found = (rd_cnt != '0);
                    REQ_KTH: begin
                        if (r_k == '0 || CW'(r_k) > CW'(rd_cnt)) begin
                            n_status = ST_RANK;
                        end else begin
                            n_node = NA'(1);
                            rd_en = 1'b1; rd_addr = {KEY_BITS'(1), r_key[KEY_BITS-1]};
                            phase = PH_KTH;
                        end
                    end
                    default: phase = PH_DONE;
                endcase
            end
            OP_UPD: upd_go = 1'b1;
            OP_KTH: begin
                if (CW'(rd_cnt) >= CW'(r_k)) begin
                    node_new = {r_node[KEY_BITS-1:0], kb};
                end else begin
                    n_k = r_k - RANK_BITS'(rd_cnt);
                    node_new = {r_node[KEY_BITS-1:0], ~kb};
                    n_ans[r_lvl] = 1'b1;
                end
                n_node = node_new;
                if (r_lvl != '0) begin
                    rd_en = 1'b1; rd_addr = {node_new[KEY_BITS-1:0], kb_nx};
                    n_lvl = lvl_dec; phase = PH_KTH;
                end
            end
            OP_CS: begin
                if (bb) begin
                    n_cacc = r_cacc + rd_cnt;
                    n_sacc = r_sacc + rd_sum;
                end
                node_new = {r_node[KEY_BITS-1:0], bb};
                n_node = node_new;
                rd_en = 1'b1;
                if (r_lvl == '0) begin
                    rd_addr = node_new; phase = PH_CSLEAF;
                end else begin
                    rd_addr = {node_new[KEY_BITS-1:0], 1'b0}; n_lvl = lvl_dec; phase = PH_CS;
                end
            end
            OP_CSLEAF: begin
                n_cacc = r_cacc + rd_cnt;
                n_sacc = r_sacc + rd_sum;
            end
            default: phase = PH_DONE;
        endcase
        if (upd_go) begin
            wr_en = 1'b1;
            wr_addr = r_node;
            if (r_req == REQ_INS) begin
                wr_data = {rd_cnt + COUNT_BITS'(1), rd_sum + SW'(r_key)};
            end else begin
                wr_data = {rd_cnt - COUNT_BITS'(1), rd_sum - SW'(r_key)};
            end
            if (r_node != NA'(1)) begin
                rd_en = 1'b1; rd_addr = r_node >> 1; n_node = r_node >> 1; phase = PH_UPD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_key <= n_key; r_k <= n_k; r_bnd <= n_bnd; r_node <= n_node;
        r_lvl <= n_lvl; r_status <= n_status; r_found <= n_found; r_ans <= n_ans;
        r_cacc <= n_cacc; r_sacc <= n_sacc;
        if (i_op == OP_LOAD) begin
            r_out_user <= r_status;
            r_out_data <= ODW'({(r_req == REQ_SUM) ? r_sacc : SW'(0),
                                (r_req == REQ_CNT) ? r_cacc : COUNT_BITS'(0),
                                (r_req == REQ_KTH && r_status == ST_OK) ? r_ans
                                                                        : KEY_BITS'(0),
                                r_found});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr <= n_clr;
            if (i_op == OP_LOAD) r_out_valid <= 1'b1;
            else if (i_tready) r_out_valid <= 1'b0;
        end
    end

    assign o_sts.phase    = phase;
    assign o_sts.clr_last = (r_clr == '1);
    assign o_sts.out_full = r_out_valid;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_user;

endmodule

`default_nettype wire

/* rtl/bto_ctrl.sv */
// Controller state machine of the trie block.
`default_nettype none

module bto_ctrl import bto_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_op          o_op
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_op = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op = OP_START;
                    n_state = ph2state(i_sts.phase);
                end
            end
            S_FIRST: begin
                o_op = OP_FIRST;
                n_state = ph2state(i_sts.phase);
            end
            S_UPD: begin
                o_op = OP_UPD;
                n_state = ph2state(i_sts.phase);
            end
            S_KTH: begin
                o_op = OP_KTH;
                n_state = ph2state(i_sts.phase);
            end
            S_CS: begin
                o_op = OP_CS;
                n_state = ph2state(i_sts.phase);
            end
            S_CSLEAF: begin
                o_op = OP_CSLEAF;
                n_state = ph2state(i_sts.phase);
            end
            S_OUT: begin
                if (!i_sts.out_full || i_out_ready) begin
                    o_op = OP_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/binary_trie_order_statistics_top.sv */
// Top level of the binary trie multiset with order statistics.
// Channel  | Dir | tdata (low bit up)               | tuser
// s_axis   | in  | key, rank, bound                 | req_type
// m_axis   | out | found, xor_value, key_count, sum | status
// After reset the node memory is cleared before the first beat is taken.
// One request at a time, one trie level per cycle through one read port of the node memory.
// A result waits in the output register while the next beat is taken.
`default_nettype none

module binary_trie_order_statistics_top import bto_pkg::*; #(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int IDW = ((2 * KEY_BITS + RANK_BITS + 1 + 7) / 8) * 8,
    localparam int ODW = ((1 + 2 * KEY_BITS + 2 * COUNT_BITS + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IDW-1:0]         i_s_axis_tdata,  // key, rank, bound
    input  wire logic [REQ_BITS-1:0]    i_s_axis_tuser,  // req_type
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [ODW-1:0]              o_m_axis_tdata,  // found, xor_value, key_count, key_sum
    output logic [STATUS_BITS-1:0]      o_m_axis_tuser   // status
);

    t_op     op;
    t_dp_sts sts;

    bto_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_op        (op)
    );

    bto_dp #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS),
        .IDW        (IDW),
        .ODW        (ODW)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_req    (i_s_axis_tuser),
        .i_data   (i_s_axis_tdata),
        .o_sts    (sts),
        .i_tready (i_m_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

/* rtl/bto_checker.sv */
// Port checker of the trie block and its bind to the top level.
`default_nettype none
`include "binary_trie_order_statistics_top_defines.svh"

module bto_checker import bto_pkg::*; #(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int IDW = ((2 * KEY_BITS + RANK_BITS + 1 + 7) / 8) * 8,
    localparam int ODW = ((1 + 2 * KEY_BITS + 2 * COUNT_BITS + 7) / 8) * 8
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic [IDW-1:0]         i_s_axis_tdata,
    input wire logic [REQ_BITS-1:0]    i_s_axis_tuser,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [ODW-1:0]         o_m_axis_tdata,
    input wire logic [STATUS_BITS-1:0] o_m_axis_tuser
);

    localparam int XLO = 1;
    localparam int CLO = 1 + KEY_BITS;
    localparam int SLO = CLO + COUNT_BITS;
    localparam int SHI = SLO + KEY_BITS + COUNT_BITS - 1;

    `BTO_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
    `BTO_ASSERT_NXT(a_busy_after_beat, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `BTO_ASSERT_IMP(a_rank_zero, o_m_axis_tvalid && o_m_axis_tuser == ST_RANK,
        o_m_axis_tdata[CLO-1:XLO] == '0)
    `BTO_ASSERT_IMP(a_count_or_sum, o_m_axis_tvalid && o_m_axis_tdata[SLO-1:CLO] != '0,
        o_m_axis_tdata[SHI:SLO] == '0 && o_m_axis_tuser == ST_OK)

endmodule

bind binary_trie_order_statistics_top bto_checker #(
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_bto_checker (.*);

`default_nettype wire

/* dv/binary_trie_order_statistics_checker.sv */
// Checker that predicts the trie multiset results and compares them with the output beats.
`timescale 1ns / 100ps

module binary_trie_order_statistics_checker import bto_pkg::*; #(
    parameter int KB = 10,
    parameter int CB = 16,
    parameter int IDW = 40,
    parameter int ODW = 56
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_req_valid,
    input  wire logic                   i_req_ready,
    input  wire logic [IDW-1:0]         i_req_data,
    input  wire logic [REQ_BITS-1:0]    i_req_kind,
    input  wire logic                   i_rsp_valid,
    input  wire logic                   i_rsp_ready,
    input  wire logic [ODW-1:0]         i_rsp_data,
    input  wire logic [STATUS_BITS-1:0] i_rsp_status,
    output int                          o_errors,
    output int                          o_pending
);

    localparam int NN = 1 << (KB + 1);
    localparam int LB = 1 << KB;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   found;
        logic [KB-1:0]          xv;
        logic [CB-1:0]          cnt;
        logic [KB+CB-1:0]       sum;
    } t_answer;

    logic [CB-1:0]    trie_cnt [NN];
    logic [KB+CB-1:0] trie_sum [NN];
    t_answer          answers_q[$];

    initial begin
        foreach (trie_cnt[i]) begin
            trie_cnt[i] = '0;
            trie_sum[i] = '0;
        end
        o_errors = 0;
    end

    assign o_pending = answers_q.size();

    function automatic void walk_path(input logic [KB-1:0] key, input bit add);
        int n;
        n = LB + key;
        while (n >= 1) begin
            if (add) begin
                trie_cnt[n] = trie_cnt[n] + 1'b1;
                trie_sum[n] = trie_sum[n] + key;
            end else begin
                trie_cnt[n] = trie_cnt[n] - 1'b1;
                trie_sum[n] = trie_sum[n] - key;
            end
            n = n >> 1;
        end
    endfunction

    function automatic t_answer serve_request(input logic [REQ_BITS-1:0] kind,
                                              input logic [KB-1:0] key,
                                              input logic [RANK_BITS-1:0] rank,
                                              input logic [KB:0] bound);
        t_answer a;
        int n, k, same, c;
        logic [CB:0]      cacc;
        logic [KB+CB:0]   sacc;
        a = '0;
        case (kind)
            REQ_INS: begin
                if (trie_cnt[1] == {CB{1'b1}}) a.status = ST_FULL;
                else walk_path(key, 1);
            end
            REQ_DEL: begin
                if (trie_cnt[LB + key] == 0) a.status = ST_ABSENT;
                else walk_path(key, 0);
            end
            REQ_MEM: a.found = trie_cnt[LB + key] != 0;
            REQ_KTH: begin
                if (rank == 0 || rank > trie_cnt[1]) begin
                    a.status = ST_RANK;
                end else begin
                    n = 1;
                    k = rank;
                    for (int i = KB - 1; i >= 0; i--) begin
                        c = key[i];
                        same = 2 * n + c;
                        if (trie_cnt[same] >= k) begin
                            n = same;
                        end else begin
                            k -= trie_cnt[same];
                            n = 2 * n + (c ^ 1);
                            a.xv[i] = 1'b1;
                        end
                    end
                end
            end
            REQ_CNT, REQ_SUM: begin
                if (!bound[KB]) begin
                    n = 1;
                    cacc = '0;
                    sacc = '0;
                    for (int i = KB - 1; i >= 0; i--) begin
                        if (bound[i]) begin
                            cacc += trie_cnt[2 * n];
                            sacc += trie_sum[2 * n];
                        end
                        n = 2 * n + bound[i];
                    end
                    cacc += trie_cnt[n];
                    sacc += trie_sum[n];
                    if (kind == REQ_CNT) a.cnt = cacc[CB-1:0];
                    else a.sum = sacc[KB+CB-1:0];
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want, got;
        if (i_rst_n && i_req_valid && i_req_ready)
            answers_q.push_back(serve_request(i_req_kind, i_req_data[KB-1:0],
                i_req_data[KB+RANK_BITS-1:KB], i_req_data[2*KB+RANK_BITS:KB+RANK_BITS]));
        if (i_rst_n && i_rsp_valid && i_rsp_ready) begin
            got.status = i_rsp_status;
            got.found  = i_rsp_data[0];
            got.xv     = i_rsp_data[KB:1];
            got.cnt    = i_rsp_data[KB+CB:KB+1];
            got.sum    = i_rsp_data[2*KB+2*CB:KB+CB+1];
            if (answers_q.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, got);
                o_errors++;
            end else begin
                want = answers_q.pop_front();
                if (got.status !== want.status || got.found !== want.found ||
                    got.xv !== want.xv || got.cnt !== want.cnt || got.sum !== want.sum) begin
                    $display("%0t: mismatch, expected st=%0d f=%0d x=%0d c=%0d s=%0d, actual st=%0d f=%0d x=%0d c=%0d s=%0d",
                        $time, want.status, want.found, want.xv, want.cnt, want.sum,
                        got.status, got.found, got.xv, got.cnt, got.sum);
                    o_errors++;
                end
            end
        end
    end

endmodule

/* dv/binary_trie_order_statistics_top_tb.sv */
// Testbench top that drives requests into the trie block and reports the verdict.
`timescale 1ns / 100ps

module binary_trie_order_statistics_top_tb import bto_pkg::*;;

    localparam int KB  = 10;
    localparam int CB  = 16;
    localparam int IDW = ((2 * KB + RANK_BITS + 1 + 7) / 8) * 8;
    localparam int ODW = ((1 + 2 * KB + 2 * CB + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IDW-1:0]         s_data = '0;
    logic [REQ_BITS-1:0]    s_kind = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [ODW-1:0]         m_data;
    logic [STATUS_BITS-1:0] m_status;
    int                     errors, pending, cycles;
    bit                     calm = 0, hold_off = 0;

    always #4 i_clk = ~i_clk;

    binary_trie_order_statistics_top #(.KEY_BITS(KB), .COUNT_BITS(CB)) dut (
        .i_clk, .i_rst_n,
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_kind),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_status)
    );

    binary_trie_order_statistics_checker #(.KB(KB), .CB(CB), .IDW(IDW), .ODW(ODW)) u_chk (
        .i_clk, .i_rst_n,
        .i_req_valid(s_valid), .i_req_ready(s_ready), .i_req_data(s_data), .i_req_kind(s_kind),
        .i_rsp_valid(m_valid), .i_rsp_ready(m_ready), .i_rsp_data(m_data),
        .i_rsp_status(m_status), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end
    initial cycles = 0;

    // Receiver: random stall bursts, one long hold-off, none near the end.
    initial begin
        int gap;
        repeat (4) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 12);
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                m_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(input logic [REQ_BITS-1:0] kind, input logic [KB-1:0] key,
                             input logic [RANK_BITS-1:0] rank, input logic [KB:0] bound);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_data  <= IDW'({bound, rank, key});
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    task automatic random_beat(input int held);
        int sel;
        logic [KB-1:0] key;
        sel = $urandom_range(0, 99);
        key = (sel < 50) ? KB'($urandom_range(0, 15)) : KB'($urandom);
        if (sel < 35) send_beat(REQ_INS, key, '0, '0);
        else if (sel < 50) send_beat(REQ_DEL, key, '0, '0);
        else if (sel < 60) send_beat(REQ_MEM, key, '0, '0);
        else if (sel < 75)
            send_beat(REQ_KTH, KB'($urandom),
                ($urandom_range(0, 9) == 0) ? RANK_BITS'($urandom)
                    : RANK_BITS'($urandom_range(0, held + 2)), '0);
        else if (sel < 86)
            send_beat(REQ_CNT, '0, '0, ($urandom_range(0, 9) == 0) ? (KB+1)'($urandom)
                : {1'b0, KB'($urandom)});
        else if (sel < 97)
            send_beat(REQ_SUM, '0, '0, ($urandom_range(0, 9) == 0) ? (KB+1)'($urandom)
                : {1'b0, KB'($urandom)});
        else send_beat(REQ_BITS'($urandom_range(6, 7)), KB'($urandom), RANK_BITS'($urandom),
            (KB+1)'($urandom));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Extremes, every kind, and the special cases.
        send_beat(REQ_KTH, '0, 16'd1, '0);
        send_beat(REQ_DEL, '1, '0, '0);
        send_beat(REQ_CNT, '0, '0, '1);
        send_beat(REQ_INS, '0, '0, '0);
        send_beat(REQ_INS, '1, '0, '0);
        send_beat(REQ_INS, '1, '0, '0);
        send_beat(REQ_MEM, '1, '0, '0);
        send_beat(REQ_MEM, 10'd5, '0, '0);
        send_beat(REQ_KTH, '1, 16'd1, '0);
        send_beat(REQ_KTH, '0, 16'd3, '0);
        send_beat(REQ_KTH, '0, 16'd0, '0);
        send_beat(REQ_KTH, '0, '1, '0);
        send_beat(REQ_CNT, '0, '0, {1'b0, {KB{1'b1}}});
        send_beat(REQ_SUM, '0, '0, {1'b0, {KB{1'b1}}});
        send_beat(REQ_SUM, '0, '0, '1);
        send_beat(REQ_CNT, '0, '0, '0);
        send_beat(REQ_DEL, '0, '0, '0);
        send_beat(REQ_MEM, '0, '0, '0);
        send_beat(3'd6, '1, '1, '1);
        send_beat(3'd7, '0, '0, '0);
        hold_off = 1;
        for (int i = 0; i < 1350; i++) begin
            if (i > 1200) calm = 1;
            random_beat(i / 3);
        end
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/bto_pkg.sv
rtl/bto_dp.sv
rtl/bto_ctrl.sv
rtl/binary_trie_order_statistics_top.sv
rtl/bto_checker.sv
dv/binary_trie_order_statistics_checker.sv
dv/binary_trie_order_statistics_top_tb.sv
